>>> rtl/bfc_pkg.sv
// bfc_pkg: shared constants, command codes, queue entry type and glyph address helper
// for the bitmap font text console; no dependencies
package bfc_pkg;

    localparam int GLYPH_STRIDE = 16;
    localparam int CELL_HEIGHT  = 16;
    localparam int CELL_WIDTH   = 8;
    localparam int GLYPH_DEPTH  = 4096;
    localparam int GADDR_W      = $clog2(GLYPH_DEPTH);
    localparam int ROW_W        = $clog2(CELL_HEIGHT);
    localparam int Y_LIMIT      = GLYPH_DEPTH - CELL_HEIGHT;
    localparam int QUEUE_DEPTH  = 2;

    localparam int X_W     = 13;
    localparam int Y_W     = 12;
    localparam int IDX_W   = 24;
    localparam int COLOR_W = 32;
    localparam int CFG_A_W = 2;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_PUT     = 2'd1;
    localparam logic [1:0] CMD_NEWLINE = 2'd2;
    localparam logic [1:0] CMD_ERASE   = 2'd3;

    localparam logic [CFG_A_W-1:0] CFG_FG     = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_BG     = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_WIDTH  = 2'd2;
    localparam logic [CFG_A_W-1:0] CFG_STRIDE = 2'd3;

    localparam logic [7:0]         FULL_MASK = 8'hff;
    localparam logic [COLOR_W-1:0] FG_RESET  = 32'hffff_ffff;
    localparam logic [COLOR_W-1:0] BG_RESET  = 32'h0000_0000;
    localparam logic [X_W-1:0]     WIDTH_RESET  = 13'd1024;
    localparam logic [X_W-1:0]     STRIDE_RESET = 13'd1024;

    typedef struct packed {
        logic [1:0]     cmd;
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
        logic [7:0]     code;
        logic [3:0]     row;
        logic [7:0]     fbyte;
    } t_job;

    function automatic logic [GADDR_W-1:0] glyph_addr(input logic [7:0] code,
                                                      input logic [3:0] row);
        int sum;
        sum = int'(code) * GLYPH_STRIDE + int'(row);
        return sum[GADDR_W-1:0];
    endfunction

endpackage

>>> rtl/bfc_front.sv
// bfc_front: accepts command words, keeps the text cursor and queues font-load and cell jobs
// depends on bfc_pkg
module bfc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_cmd,
    input  logic [7:0]           i_code,
    input  logic [3:0]           i_row,
    input  logic [7:0]           i_fbyte,
    input  logic [bfc_pkg::X_W-1:0] i_width,
    input  logic                 i_full,
    output logic                 o_push,
    output bfc_pkg::t_job        o_job
);
    import bfc_pkg::*;

    logic [X_W-1:0] r_x, n_x;
    logic [Y_W-1:0] r_y, n_y;
    logic [X_W-1:0] x_inc, ex, left;
    logic [X_W:0]   x_end;
    logic [Y_W:0]   yd;
    logic [Y_W-1:0] y_dn, y_up, ey;
    logic           accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        x_inc = r_x + X_W'(CELL_WIDTH);
        x_end = {1'b0, x_inc} + (X_W+1)'(CELL_WIDTH);
        yd    = {1'b0, r_y} + (Y_W+1)'(CELL_HEIGHT);
        y_dn  = (yd > (Y_W+1)'(Y_LIMIT)) ? Y_W'(Y_LIMIT) : yd[Y_W-1:0];
        y_up  = (r_y >= Y_W'(CELL_HEIGHT)) ? r_y - Y_W'(CELL_HEIGHT) : '0;
        ex    = (r_x == '0) ? i_width : r_x;
        ey    = (r_x == '0) ? y_up : r_y;
        left  = (ex >= X_W'(CELL_WIDTH)) ? ex - X_W'(CELL_WIDTH) : '0;

        n_x = r_x;
        n_y = r_y;
        o_push = 1'b0;
        o_job.cmd   = i_cmd;
        o_job.x     = r_x;
        o_job.y     = r_y;
        o_job.code  = i_code;
        o_job.row   = i_row;
        o_job.fbyte = i_fbyte;
        if (accept) begin
            unique case (i_cmd)
                CMD_LOAD: begin
                    o_push = 1'b1;
                end
                CMD_PUT: begin
                    o_push = 1'b1;
                    if (x_end > {1'b0, i_width}) begin
                        n_x = '0;
                        n_y = y_dn;
                    end else begin
                        n_x = x_inc;
                    end
                end
                CMD_NEWLINE: begin
                    n_x = '0;
                    n_y = y_dn;
                end
                CMD_ERASE: begin
                    o_push  = 1'b1;
                    o_job.x = left;
                    o_job.y = ey;
                    n_x     = left;
                    n_y     = ey;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

endmodule

>>> rtl/bfc_queue.sv
// bfc_queue: short job queue between front and back
// depends on bfc_pkg
module bfc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bfc_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output bfc_pkg::t_job o_job
);
    import bfc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

endmodule

>>> rtl/bfc_back.sv
// bfc_back: glyph store and row sequencer, emits one masked row word per cycle while the output is free
// depends on bfc_pkg
module bfc_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    input  bfc_pkg::t_job                i_job,
    output logic                         o_pop,
    input  logic [bfc_pkg::COLOR_W-1:0]  i_fg,
    input  logic [bfc_pkg::COLOR_W-1:0]  i_bg,
    input  logic [bfc_pkg::X_W-1:0]      i_stride,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bfc_pkg::IDX_W-1:0]    o_index,
    output logic [7:0]                   o_mask,
    output logic [bfc_pkg::COLOR_W-1:0]  o_color,
    output logic                         o_last
);
    import bfc_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_ROW  = 1'b1;
    localparam int   PROD_W  = X_W + Y_W;

    logic [7:0]         r_glyph [GLYPH_DEPTH];
    logic [7:0]         r_rdata;
    logic [0:0]         r_state, n_state;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [7:0]         r_code, n_code;
    logic               r_erase, n_erase;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [PROD_W-1:0]  prod;
    logic               mem_we;
    logic               out_free, emit, row_last;

    logic               r_ovalid;
    logic [IDX_W-1:0]   r_oindex;
    logic [7:0]         r_omask;
    logic [COLOR_W-1:0] r_ocolor;
    logic               r_olast;

    assign out_free = !r_ovalid || i_ready;
    assign row_last = (r_row == ROW_W'(CELL_HEIGHT - 1));
    assign prod     = PROD_W'(i_job.y) * PROD_W'(i_stride);

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_code  = r_code;
        n_erase = r_erase;
        n_idx   = r_idx;
        o_pop   = 1'b0;
        mem_we  = 1'b0;
        emit    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_pop = 1'b1;
                    if (i_job.cmd == CMD_LOAD) begin
                        mem_we = 1'b1;
                    end else begin
                        n_state = ST_ROW;
                        n_row   = '0;
                        n_code  = i_job.code;
                        n_erase = (i_job.cmd == CMD_ERASE);
                        n_idx   = prod[IDX_W-1:0] + IDX_W'(i_job.x);
                    end
                end
            end
            ST_ROW: begin
                if (out_free) begin
                    emit  = 1'b1;
                    n_row = r_row + 1'b1;
                    n_idx = r_idx + IDX_W'(i_stride);
                    if (row_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // read address follows the next row so the data lines up with r_row
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_glyph[glyph_addr(i_job.code, i_job.row)] <= i_job.fbyte;
        end
        r_rdata <= r_glyph[glyph_addr(n_code, 4'(n_row))];
    end

    always_ff @(posedge i_clk) begin
        r_row   <= n_row;
        r_code  <= n_code;
        r_erase <= n_erase;
        r_idx   <= n_idx;
        if (emit) begin
            r_oindex <= r_idx;
            r_omask  <= r_erase ? FULL_MASK : r_rdata;
            r_ocolor <= r_erase ? i_bg : i_fg;
            r_olast  <= row_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_index = r_oindex;
    assign o_mask  = r_omask;
    assign o_color = r_ocolor;
    assign o_last  = r_olast;

endmodule

>>> rtl/bitmap_font_text_console_top.sv
// bitmap_font_text_console_top: console writer top, config registers and part wiring
// depends on bfc_pkg, bfc_front, bfc_queue, bfc_back
//
//   channel  dir  handshake                 payload
//   s_axis   in   tvalid / tready           tuser cmd, tdata code/row/byte
//   m_axis   out  tvalid / tready           tdata index/mask/color, tlast
//   cfg      in   we                        addr, wdata
//
// a put-char or erase in the back first fetches the job and starts the first glyph read,
// then emits one row word per cycle from the glyph store port while the output is ready
// a font load is written by the back while idle; a newline never reaches the back
// synchronous active-low reset clears cursor, queue, sequencer and output valid
// the glyph store has no reset; the two-entry queue lets the front take words
// while the back is stalled by the output side
module bitmap_font_text_console_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // char_code, font_row, font_byte, zero pad
    input  logic [1:0]  i_s_axis_tuser,   // cmd
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // pixel_index, pixel_mask, pixel_color
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [bfc_pkg::CFG_A_W-1:0] i_cfg_addr,
    input  logic [31:0] i_cfg_wdata
);
    import bfc_pkg::*;

    logic [COLOR_W-1:0] r_fg, r_bg;
    logic [X_W-1:0]     r_width, r_stride;

    logic               push, full, pop, job_valid;
    t_job               front_job, back_job;
    logic [IDX_W-1:0]   pix_index;
    logic [7:0]         pix_mask;
    logic [COLOR_W-1:0] pix_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg     <= FG_RESET;
            r_bg     <= BG_RESET;
            r_width  <= WIDTH_RESET;
            r_stride <= STRIDE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_FG:     r_fg     <= i_cfg_wdata;
                CFG_BG:     r_bg     <= i_cfg_wdata;
                CFG_WIDTH:  r_width  <= i_cfg_wdata[X_W-1:0];
                CFG_STRIDE: r_stride <= i_cfg_wdata[X_W-1:0];
                default: ;
            endcase
        end
    end

    bfc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_cmd   (i_s_axis_tuser),
        .i_code  (i_s_axis_tdata[7:0]),
        .i_row   (i_s_axis_tdata[11:8]),
        .i_fbyte (i_s_axis_tdata[19:12]),
        .i_width (r_width),
        .i_full  (full),
        .o_push  (push),
        .o_job   (front_job)
    );

    bfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_job   (back_job)
    );

    bfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (back_job),
        .o_pop       (pop),
        .i_fg        (r_fg),
        .i_bg        (r_bg),
        .i_stride    (r_stride),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_index     (pix_index),
        .o_mask      (pix_mask),
        .o_color     (pix_color),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {pix_color, pix_mask, pix_index};

endmodule

>>> rtl/bfc_checker.sv
// bfc_checker: port-level checks on the row word stream, bound to the top level
// depends on bfc_pkg, bitmap_font_text_console_top
module bfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic [63:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);
    import bfc_pkg::*;

    logic [ROW_W-1:0] r_cnt;
    logic [31:0]      r_prev_color;
    logic             out_acc;

    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (out_acc) begin
            r_cnt <= o_m_axis_tlast ? '0 : r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_acc) begin
            r_prev_color <= o_m_axis_tdata[63:32];
        end
    end

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled word changed");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (r_cnt == ROW_W'(CELL_HEIGHT - 1))))
        else $error("tlast not on final cell row");

    a_cell_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (r_cnt != '0) |-> (o_m_axis_tdata[63:32] == r_prev_color))
        else $error("color changed within a cell");

endmodule

bind bitmap_font_text_console_top bfc_checker u_bfc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

>>> sim/bitmap_font_text_console_top_tb.sv
// bitmap_font_text_console_top_tb: drives font loads, put-char, newline and erase words
// into the console writer and checks every row write against a cycle-free predictor
// depends on bfc_pkg and bitmap_font_text_console_top
`timescale 1ns / 1ps

module bitmap_font_text_console_top_tb;
    import bfc_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]   index;
        logic [7:0]         mask;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_row_write;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [23:0] s_data = '0;
    logic [1:0]  s_user = CMD_NEWLINE;
    logic        m_ready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [CFG_A_W-1:0] cfg_addr = CFG_FG;
    logic [31:0] cfg_data = '0;

    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [63:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;

    bitmap_font_text_console_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),     // char_code, font_row, font_byte, zero pad
        .i_s_axis_tuser  (s_user),     // cmd
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata), // pixel_index, pixel_mask, pixel_color
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // predicted console state
    logic [7:0]         font_mem [GLYPH_DEPTH];
    logic [15:0]        rows_written [256];
    int                 glyph_ready[$];
    logic [X_W-1:0]     cur_x = '0;
    logic [Y_W-1:0]     cur_y = '0;
    logic [COLOR_W-1:0] fg_q = FG_RESET;
    logic [COLOR_W-1:0] bg_q = BG_RESET;
    logic [X_W-1:0]     width_q = WIDTH_RESET;
    logic [X_W-1:0]     stride_q = STRIDE_RESET;

    t_row_write pending_rows[$];
    int         err_count = 0;
    int         send_idle_pct = 23;
    int         recv_idle_pct = 77;

    task automatic queue_cell(input int x, input int y, input bit erase,
                              input logic [7:0] code);
        t_row_write w;
        longint unsigned lin;
        int addr;
        for (int r = 0; r < CELL_HEIGHT; r++) begin
            lin = longint'(x) + longint'(y + r) * longint'(stride_q);
            addr = (int'(code) * GLYPH_STRIDE + r) % GLYPH_DEPTH;
            w.index = lin[IDX_W-1:0];
            w.mask  = erase ? FULL_MASK : font_mem[addr];
            w.color = erase ? bg_q : fg_q;
            w.last  = (r == CELL_HEIGHT - 1);
            pending_rows.push_back(w);
        end
    endtask

    task automatic cursor_down();
        int ny;
        ny = int'(cur_y) + CELL_HEIGHT;
        cur_y = (ny > Y_LIMIT) ? Y_W'(Y_LIMIT) : Y_W'(ny);
    endtask

    task automatic console_step(input logic [1:0] cmd, input logic [7:0] code,
                                input logic [3:0] row, input logic [7:0] fbyte);
        int nx;
        int left;
        case (cmd)
            CMD_LOAD: begin
                font_mem[(int'(code) * GLYPH_STRIDE + int'(row)) % GLYPH_DEPTH] = fbyte;
                if (rows_written[code] != 16'hffff) begin
                    rows_written[code][row] = 1'b1;
                    if (rows_written[code] == 16'hffff)
                        glyph_ready.push_back(int'(code));
                end
            end
            CMD_PUT: begin
                queue_cell(int'(cur_x), int'(cur_y), 1'b0, code);
                nx = (int'(cur_x) + CELL_WIDTH) & 32'h1fff;
                if (nx + CELL_WIDTH > int'(width_q)) begin
                    nx = 0;
                    cursor_down();
                end
                cur_x = X_W'(nx);
            end
            CMD_NEWLINE: begin
                cur_x = '0;
                cursor_down();
            end
            default: begin
                if (cur_x == 0) begin
                    cur_x = width_q;
                    cur_y = (cur_y >= CELL_HEIGHT) ? Y_W'(cur_y - CELL_HEIGHT) : '0;
                end
                left = (int'(cur_x) >= CELL_WIDTH) ? int'(cur_x) - CELL_WIDTH : 0;
                queue_cell(left, int'(cur_y), 1'b1, 8'd0);
                cur_x = X_W'(left);
            end
        endcase
    endtask

    task automatic send_word(input logic [1:0] cmd, input logic [7:0] code,
                             input logic [3:0] row, input logic [7:0] fbyte);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= {4'b0, fbyte, row, code};
        do @(posedge i_clk); while (!o_s_axis_tready);
        console_step(cmd, code, row, fbyte);
    endtask

    task automatic send_random_fields(input logic [1:0] cmd);
        send_word(cmd, 8'($urandom), 4'($urandom), 8'($urandom));
    endtask

    task automatic put_char(input logic [7:0] code);
        send_word(CMD_PUT, code, 4'($urandom), 8'($urandom));
    endtask

    task automatic load_glyph(input logic [7:0] code);
        for (int r = 0; r < 16; r++)
            send_word(CMD_LOAD, code, 4'(r), 8'($urandom));
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] addr, input logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge i_clk);
        case (addr)
            CFG_FG:     fg_q = data;
            CFG_BG:     bg_q = data;
            CFG_WIDTH:  width_q = data[X_W-1:0];
            default:    stride_q = data[X_W-1:0];
        endcase
    endtask

    task automatic set_config(input logic [31:0] fg, input logic [31:0] bg,
                              input int width, input int stride);
        settle();
        write_reg(CFG_FG, fg);
        write_reg(CFG_BG, bg);
        write_reg(CFG_WIDTH, 32'(width));
        write_reg(CFG_STRIDE, 32'(stride));
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk)
        m_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        t_row_write want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (pending_rows.size() == 0) begin
                $error("unexpected row word index %h", o_m_axis_tdata[23:0]);
                err_count++;
            end else begin
                want = pending_rows.pop_front();
                if (o_m_axis_tdata[23:0] !== want.index) begin
                    $error("pixel_index expected %h got %h", want.index, o_m_axis_tdata[23:0]);
                    err_count++;
                end
                if (o_m_axis_tdata[31:24] !== want.mask) begin
                    $error("pixel_mask expected %h got %h", want.mask, o_m_axis_tdata[31:24]);
                    err_count++;
                end
                if (o_m_axis_tdata[63:32] !== want.color) begin
                    $error("pixel_color expected %h got %h", want.color,
                           o_m_axis_tdata[63:32]);
                    err_count++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $error("last_row expected %b got %b", want.last, o_m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    task automatic test_font_load();
        logic [7:0] b;
        for (int r = 0; r < 16; r++) begin
            b = (r == 0) ? 8'h00 : (r == 1) ? 8'hff : (r == 2) ? 8'h80 :
                (r == 3) ? 8'h01 : 8'($urandom);
            send_word(CMD_LOAD, 8'hff, 4'(r), b);
        end
        for (int r = 15; r >= 0; r--)
            send_word(CMD_LOAD, 8'h00, 4'(r), 8'($urandom));
    endtask

    // erase from the home position stays on the top text row
    task automatic test_erase_top();
        send_random_fields(CMD_ERASE);
    endtask

    task automatic test_put_and_wrap();
        put_char(8'hff);
        put_char(8'h00);
        set_config(32'h0, 32'hffff_ffff, 8, 8);
        put_char(8'hff);
        put_char(8'h00);
        send_random_fields(CMD_NEWLINE);
        put_char(8'hff);
    endtask

    task automatic test_erase();
        set_config(32'h89ab_cdef, 32'h1234_5678, 13, 1000);
        send_random_fields(CMD_NEWLINE);
        send_random_fields(CMD_ERASE);
        send_random_fields(CMD_ERASE);
        send_random_fields(CMD_ERASE);
        send_random_fields(CMD_ERASE);
        put_char(8'h00);
        send_random_fields(CMD_ERASE);
    endtask

    task automatic test_bottom_edge();
        set_config(32'hffff_ffff, 32'h0, 4096, 4096);
        for (int i = 0; i < 256; i++)
            send_random_fields(CMD_NEWLINE);
        set_config(32'h5555_aaaa, 32'haaaa_5555, 4096, 4096);
        send_random_fields(CMD_ERASE);
        put_char(8'hff);
        send_random_fields(CMD_NEWLINE);
        put_char(8'hff);
        set_config(32'hffff_ffff, 32'h0, 24, 4096);
        put_char(8'h00);
        put_char(8'hff);
        put_char(8'h00);
        put_char(8'hff);
    endtask

    task automatic test_random(input int n_items);
        int done;
        int pick;
        done = 0;
        while (done < n_items) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                load_glyph(8'($urandom));
                done += 16;
            end else begin
                if (pick < 12)
                    send_random_fields(CMD_LOAD);
                else if (pick < 70)
                    put_char(8'(glyph_ready[$urandom_range(glyph_ready.size() - 1)]));
                else if (pick < 82)
                    send_random_fields(CMD_NEWLINE);
                else
                    send_random_fields(CMD_ERASE);
                done++;
            end
        end
    endtask

    task automatic random_config();
        int w;
        int pick;
        pick = $urandom_range(2);
        w = (pick == 0) ? 8 : (pick == 1) ? $urandom_range(8, 200) : $urandom_range(8, 4096);
        set_config($urandom, $urandom, w, $urandom_range(8, 4096));
    endtask

    initial begin
        for (int c = 0; c < 256; c++)
            rows_written[c] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_font_load();
        test_erase_top();
        test_put_and_wrap();
        test_erase();
        test_bottom_edge();

        random_config();
        test_random(12);
        send_idle_pct = 77;
        recv_idle_pct = 23;
        random_config();
        test_random(12);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_config();
        test_random(12);

        settle();
        if (err_count == 0)
            $display("bitmap_font_text_console_top_tb: clean");
        else
            $display("bitmap_font_text_console_top_tb: errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("bitmap_font_text_console_top_tb: errors");
        $finish;
    end

endmodule

>>> bitmap_font_text_console_top.f
rtl/bfc_pkg.sv
rtl/bfc_front.sv
rtl/bfc_queue.sv
rtl/bfc_back.sv
rtl/bitmap_font_text_console_top.sv
rtl/bfc_checker.sv
sim/bitmap_font_text_console_top_tb.sv
